@@ design/mrope_pkg.sv @@
// Package with item types, pipeline cell types, register codes and constant tables.
`default_nettype none
package mrope_pkg;

    localparam int MAX_HEAD_DIM      = 512;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int DIV_STAGES        = 30;
    localparam int EXP_STAGES        = 16;
    localparam int MOD_STAGES        = 15;

    localparam logic [32:0] TWO_PI_Q30     = 33'd6746518852;
    localparam logic [34:0] PI_Q30         = 35'd3373259426;
    localparam logic [34:0] HALF_PI_Q30    = 35'd1686629713;
    localparam logic [33:0] CORDIC_GAIN    = 34'd652032874;
    localparam logic [20:0] LOG2_10000_Q16 = 21'd870824;
    localparam logic [30:0] Q30_ONE        = 31'h4000_0000;

    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_SEC_T     = 3'd1,
        REG_SEC_H     = 3'd2,
        REG_SEC_W     = 3'd3,
        REG_HEAD      = 3'd4,
        REG_LOG2_BASE = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        logic signed [15:0] x_first;
        logic signed [15:0] x_second;
        logic [7:0]         pair_index;
        logic [15:0]        pos_t;
        logic [15:0]        pos_h;
        logic [15:0]        pos_w;
    } x_item_t;

    typedef struct packed {
        logic signed [15:0] y_first;
        logic signed [15:0] y_second;
        logic               saturated;
    } y_item_t;

    // Fields that ride along the divider, exponent, reduction and CORDIC stages.
    typedef struct packed {
        logic               valid;
        logic signed [15:0] x_first;
        logic signed [15:0] x_second;
        logic [15:0]        pos;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [9:0]  size;
        logic [9:0]  rem;
        logic [29:0] num;
        logic [29:0] quo;
    } div_t;

    typedef struct packed {
        side_t       side;
        logic [29:0] e;
        logic [30:0] m;
    } exp_t;

    typedef struct packed {
        side_t       side;
        logic [46:0] v;
    } mod_t;

    typedef struct packed {
        side_t              side;
        logic               neg;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } cord_t;

    localparam logic [30:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
        31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
        31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
        31'd262144,    31'd131072,    31'd65536,     31'd32768,
        31'd16384,     31'd8192,      31'd4096,      31'd2048,
        31'd1024,      31'd512,       31'd256,       31'd128
    };

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Q30 value of 2^(-2^-(k+1)); evaluated only at elaboration.
    function automatic logic [30:0] exp_tab(input int k);
        logic [63:0] t;
        t = isqrt64(64'd1 << 59);
        for (int j = 1; j < EXP_STAGES; j++)
        begin
            if (j <= k)
            begin
                t = isqrt64(t << 30);
            end
        end
        return t[30:0];
    endfunction

endpackage
`default_nettype wire

@@ design/mrope_div_cell.sv @@
// One restoring division cell: produces one quotient bit of the exponent.
`default_nettype none
module mrope_div_cell #(
    parameter int K = 0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire mrope_pkg::div_t d,
    output mrope_pkg::div_t      q
);
    import mrope_pkg::*;

    div_t        st_reg;
    div_t        st_next;
    logic [10:0] trial;

    always_comb
    begin
        st_next = d;
        trial   = {d.rem, d.num[K]};
        if (trial >= {1'b0, d.size})
        begin
            st_next.rem    = 10'(trial - {1'b0, d.size});
            st_next.quo[K] = 1'b1;
        end
        else
        begin
            st_next.rem = trial[9:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign q = st_reg;
endmodule
`default_nettype wire

@@ design/mrope_exp_cell.sv @@
// One exponent cell: multiplies by 2^(-2^-(K+1)) when its fraction bit is set.
`default_nettype none
module mrope_exp_cell #(
    parameter int K = 0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire mrope_pkg::exp_t d,
    output mrope_pkg::exp_t      q
);
    import mrope_pkg::*;

    localparam logic [30:0] TAB = exp_tab(K);

    exp_t        st_reg;
    exp_t        st_next;
    logic [61:0] prod;

    always_comb
    begin
        st_next = d;
        prod    = 62'(d.m) * 62'(TAB);
        if (d.e[EXP_STAGES-1-K])
        begin
            st_next.m = prod[60:30];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign q = st_reg;
endmodule
`default_nettype wire

@@ design/mrope_mod_cell.sv @@
// One angle reduction cell: takes off 2*pi times 2^K when it fits.
`default_nettype none
module mrope_mod_cell #(
    parameter int K = 0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire mrope_pkg::mod_t d,
    output mrope_pkg::mod_t      q
);
    import mrope_pkg::*;

    localparam logic [47:0] SUB = 48'(TWO_PI_Q30) << K;

    mod_t st_reg;
    mod_t st_next;

    always_comb
    begin
        st_next = d;
        if ({1'b0, d.v} >= SUB)
        begin
            st_next.v = 47'({1'b0, d.v} - SUB);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign q = st_reg;
endmodule
`default_nettype wire

@@ design/mrope_cordic_cell.sv @@
// One CORDIC rotation cell.
`default_nettype none
module mrope_cordic_cell #(
    parameter int I = 0
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire mrope_pkg::cord_t d,
    output mrope_pkg::cord_t      q
);
    import mrope_pkg::*;

    localparam logic signed [33:0] ATAN = $signed(34'(ATAN_Q30[I]));

    cord_t              st_reg;
    cord_t              st_next;
    logic signed [33:0] dx;
    logic signed [33:0] dy;

    always_comb
    begin
        st_next = d;
        dx      = d.y >>> I;
        dy      = d.x >>> I;
        if (!d.z[33])
        begin
            st_next.x = d.x - dx;
            st_next.y = d.y + dy;
            st_next.z = d.z - ATAN;
        end
        else
        begin
            st_next.x = d.x + dx;
            st_next.y = d.y - dy;
            st_next.z = d.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign q = st_reg;
endmodule
`default_nettype wire

@@ design/multimodal_rotary_position_embed_top.sv @@
// Top level of the multimodal rotary position embedding pipeline.
//
//  Channel | Direction | Handshake            | Content
//  x       | in        | x_valid / x_ready    | x_item: element pair, pair index, positions
//  y       | out       | y_valid / y_ready    | y_item: rotated pair and saturation flag
//  cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data: register write
//
// One item enters per clock cycle while the output register is free or being emptied.
// An item passes through one select stage, 30 divider cells, 16 exponent cells,
// one frequency stage, 15 reduction cells, one fold stage, the CORDIC cells, one
// product stage and the output register. Reset clears all valid bits and loads the
// register defaults. When the output item is not taken, the whole chain holds and
// x_ready falls in the same cycle, so x_ready follows y_ready combinationally while
// an output item waits.
`default_nettype none
module multimodal_rotary_position_embed_top #(
    parameter int CORDIC_STAGES = mrope_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              x_valid,
    output logic                   x_ready,
    input  wire mrope_pkg::x_item_t x_item,
    output logic                   y_valid,
    input  wire logic              y_ready,
    output mrope_pkg::y_item_t     y_item,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [20:0]       cfg_data
);
    import mrope_pkg::*;

    // The chain advances whenever the output register is free or being emptied.
    logic adv;

    // Configuration registers. The interleaved section size is worked out at write.
    logic        mode_reg;
    logic [9:0]  sec_t_reg;
    logic [9:0]  sec_h_reg;
    logic [9:0]  sec_w_reg;
    logic [9:0]  il_size_reg;
    logic [20:0] log2_base_reg;
    logic [9:0]  head_sat;
    logic [20:0] il_prod;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        head_sat = (cfg_data[9:0] > 10'(MAX_HEAD_DIM)) ? 10'(MAX_HEAD_DIM) : cfg_data[9:0];
        // Divide by three with a reciprocal; exact for values up to MAX_HEAD_DIM + 2.
        il_prod  = 21'(11'(head_sat) + 11'd2) * 21'd683;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            sec_t_reg     <= 10'd32;
            sec_h_reg     <= 10'd48;
            sec_w_reg     <= 10'd48;
            il_size_reg   <= 10'd43;
            log2_base_reg <= 21'd870822;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:      mode_reg      <= cfg_data[0];
                REG_SEC_T:     sec_t_reg     <= cfg_data[9:0];
                REG_SEC_H:     sec_h_reg     <= cfg_data[9:0];
                REG_SEC_W:     sec_w_reg     <= cfg_data[9:0];
                REG_HEAD:      il_size_reg   <= il_prod[20:11];
                REG_LOG2_BASE: log2_base_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Section selection and the exponent numerator lb * 2 * local.
    div_t        div_chain [DIV_STAGES+1];
    div_t        sel_next;
    logic [7:0]  d;
    logic [15:0] d_mul;
    logic [6:0]  d_div3;
    logic [7:0]  d_mod3;
    logic [8:0]  half_t;
    logic [8:0]  half_h;
    logic [9:0]  half_th;
    logic [7:0]  local_idx;
    logic [20:0] lb;
    logic [28:0] num_half;

    always_comb
    begin
        d       = x_item.pair_index;
        d_mul   = 16'(d) * 16'd171;
        d_div3  = d_mul[15:9];
        d_mod3  = d - 8'(8'(d_div3) * 8'd3);
        half_t  = sec_t_reg[9:1];
        half_h  = sec_h_reg[9:1];
        half_th = 10'(half_t) + 10'(half_h);

        sel_next              = '0;
        sel_next.side.valid   = x_valid;
        sel_next.side.x_first = x_item.x_first;
        sel_next.side.x_second= x_item.x_second;

        if (mode_reg)
        begin
            case (d_mod3[1:0])
                2'd0:    sel_next.side.pos = x_item.pos_t;
                2'd1:    sel_next.side.pos = x_item.pos_h;
                default: sel_next.side.pos = x_item.pos_w;
            endcase
            local_idx     = 8'(d_div3);
            sel_next.size = il_size_reg;
            lb            = LOG2_10000_Q16;
        end
        else
        begin
            if (9'(d) < half_t)
            begin
                sel_next.side.pos = x_item.pos_t;
                local_idx         = d;
                sel_next.size     = sec_t_reg;
            end
            else if (10'(d) < half_th)
            begin
                sel_next.side.pos = x_item.pos_h;
                local_idx         = d - half_t[7:0];
                sel_next.size     = sec_h_reg;
            end
            else
            begin
                sel_next.side.pos = x_item.pos_w;
                local_idx         = d - half_th[7:0];
                sel_next.size     = sec_w_reg;
            end
            lb = log2_base_reg;
        end
        num_half     = 29'(lb) * 29'(local_idx);
        sel_next.num = {num_half, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_chain[0] <= '0;
        end
        else if (adv)
        begin
            div_chain[0] <= sel_next;
        end
    end

    // Divider row: one quotient bit per cell, most significant first.
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        mrope_div_cell #(.K(DIV_STAGES - 1 - g)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .d     (div_chain[g]),
            .q     (div_chain[g+1])
        );
    end

    // Exponent row. A zero section size gives a zero exponent.
    exp_t exp_chain [EXP_STAGES+1];

    always_comb
    begin
        exp_chain[0].side = div_chain[DIV_STAGES].side;
        exp_chain[0].e    = (div_chain[DIV_STAGES].size == '0) ? '0
                                                                : div_chain[DIV_STAGES].quo;
        exp_chain[0].m    = Q30_ONE;
    end

    for (genvar g = 0; g < EXP_STAGES; g++)
    begin : g_exp
        mrope_exp_cell #(.K(g)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .d     (exp_chain[g]),
            .q     (exp_chain[g+1])
        );
    end

    // Frequency from the integer part of the exponent, then angle = pos * freq.
    mod_t        mod_chain [MOD_STAGES+1];
    mod_t        ang_next;
    logic [13:0] e_int;
    logic [30:0] freq;

    always_comb
    begin
        e_int = exp_chain[EXP_STAGES].e[29:16];
        freq  = (e_int > 14'd30) ? '0 : (exp_chain[EXP_STAGES].m >> e_int[4:0]);
        ang_next.side = exp_chain[EXP_STAGES].side;
        ang_next.v    = 47'(exp_chain[EXP_STAGES].side.pos) * 47'(freq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_chain[0] <= '0;
        end
        else if (adv)
        begin
            mod_chain[0] <= ang_next;
        end
    end

    // Reduction row: each cell subtracts 2*pi times a falling power of two when it fits.
    for (genvar g = 0; g < MOD_STAGES; g++)
    begin : g_mod
        mrope_mod_cell #(.K(MOD_STAGES - 1 - g)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .d     (mod_chain[g]),
            .q     (mod_chain[g+1])
        );
    end

    // Map the angle into (-pi, pi] and fold it into [-pi/2, pi/2].
    cord_t              cord_chain [CORDIC_STAGES+1];
    cord_t              fold_next;
    logic signed [34:0] r0;
    logic signed [34:0] r1;

    always_comb
    begin
        r0 = $signed({2'b00, mod_chain[MOD_STAGES].v[32:0]});
        r1 = (r0 > $signed(PI_Q30)) ? r0 - $signed({2'b00, TWO_PI_Q30}) : r0;
        fold_next.side = mod_chain[MOD_STAGES].side;
        fold_next.neg  = 1'b0;
        fold_next.x    = $signed(CORDIC_GAIN);
        fold_next.y    = '0;
        if (r1 > $signed(HALF_PI_Q30))
        begin
            fold_next.z   = 34'(r1 - $signed(PI_Q30));
            fold_next.neg = 1'b1;
        end
        else if (r1 < -$signed(HALF_PI_Q30))
        begin
            fold_next.z   = 34'(r1 + $signed(PI_Q30));
            fold_next.neg = 1'b1;
        end
        else
        begin
            fold_next.z = 34'(r1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cord_chain[0] <= '0;
        end
        else if (adv)
        begin
            cord_chain[0] <= fold_next;
        end
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        mrope_cordic_cell #(.I(g)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .d     (cord_chain[g]),
            .q     (cord_chain[g+1])
        );
    end

    // Product stage: undo the fold and form the four products.
    logic               prod_valid_reg;
    logic signed [49:0] p_xc_reg;
    logic signed [49:0] p_ys_reg;
    logic signed [49:0] p_xs_reg;
    logic signed [49:0] p_yc_reg;
    logic signed [33:0] cos_v;
    logic signed [33:0] sin_v;

    always_comb
    begin
        cos_v = cord_chain[CORDIC_STAGES].neg ? -cord_chain[CORDIC_STAGES].x
                                              : cord_chain[CORDIC_STAGES].x;
        sin_v = cord_chain[CORDIC_STAGES].neg ? -cord_chain[CORDIC_STAGES].y
                                              : cord_chain[CORDIC_STAGES].y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            prod_valid_reg <= cord_chain[CORDIC_STAGES].side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_xc_reg <= 50'(cord_chain[CORDIC_STAGES].side.x_first) * 50'(cos_v);
            p_ys_reg <= 50'(cord_chain[CORDIC_STAGES].side.x_second) * 50'(sin_v);
            p_xs_reg <= 50'(cord_chain[CORDIC_STAGES].side.x_first) * 50'(sin_v);
            p_yc_reg <= 50'(cord_chain[CORDIC_STAGES].side.x_second) * 50'(cos_v);
        end
    end

    // Round half up, dropping the Q30 fraction of cos and sin, and clip to 16 bits.
    localparam logic signed [50:0] ROUND_Q30 = 51'sd536870912;

    logic signed [50:0] sum0;
    logic signed [50:0] sum1;
    logic signed [20:0] w0;
    logic signed [20:0] w1;
    y_item_t            y_next;
    y_item_t            y_item_reg;
    logic               y_valid_reg;

    always_comb
    begin
        sum0 = 51'(p_xc_reg) - 51'(p_ys_reg) + ROUND_Q30;
        sum1 = 51'(p_xs_reg) + 51'(p_yc_reg) + ROUND_Q30;
        w0   = sum0[50:30];
        w1   = sum1[50:30];
        y_next.saturated = 1'b0;
        if (w0 > 21'sd32767)
        begin
            y_next.y_first   = 16'sh7FFF;
            y_next.saturated = 1'b1;
        end
        else if (w0 < -21'sd32768)
        begin
            y_next.y_first   = 16'sh8000;
            y_next.saturated = 1'b1;
        end
        else
        begin
            y_next.y_first = w0[15:0];
        end
        if (w1 > 21'sd32767)
        begin
            y_next.y_second  = 16'sh7FFF;
            y_next.saturated = 1'b1;
        end
        else if (w1 < -21'sd32768)
        begin
            y_next.y_second  = 16'sh8000;
            y_next.saturated = 1'b1;
        end
        else
        begin
            y_next.y_second = w1[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            y_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y_item_reg <= y_next;
        end
    end

    assign adv     = !y_valid_reg || y_ready;
    assign x_ready = adv;
    assign y_valid = y_valid_reg;
    assign y_item  = y_item_reg;

endmodule
`default_nettype wire

@@ design/mrope_checker.sv @@
// Port checker for the rotary embedding top level, with its bind statement.
`default_nettype none
module mrope_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               x_valid,
    input wire logic               x_ready,
    input wire logic               y_valid,
    input wire logic               y_ready,
    input wire mrope_pkg::y_item_t y_item,
    input wire logic               cfg_ready
);
    import mrope_pkg::*;

    // A result that is not taken stays in place.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        y_valid && !y_ready |=> y_valid && $stable(y_item))
        else $error("output item changed while stalled");

    // With the output register empty the pipeline must take input.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !y_valid |-> x_ready)
        else $error("input stalled with empty output register");

    // An unclipped pair never raises the flag.
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        y_valid && y_item.y_first != 16'sh7FFF && y_item.y_first != 16'sh8000
        && y_item.y_second != 16'sh7FFF && y_item.y_second != 16'sh8000
        |-> !y_item.saturated)
        else $error("saturation flag without clipped result");

    // Register writes are never refused.
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind multimodal_rotary_position_embed_top mrope_checker u_mrope_checker (.*);
`default_nettype wire

@@ bench/multimodal_rotary_position_embed_top_tb.sv @@
// Self-checking testbench for the multimodal rotary position embedding pipeline.
`timescale 1ns / 1ps
`default_nettype none
module multimodal_rotary_position_embed_top_tb;
    import mrope_pkg::*;

    // Register index that maps to no register; writes to it must change nothing.
    localparam logic [2:0] REG_NONE = 3'd6;
    localparam int PIPE_LATENCY = 82;

    // One register setting for a phase of the run.
    typedef struct {
        logic        mode;
        logic [9:0]  sec_t;
        logic [9:0]  sec_h;
        logic [9:0]  sec_w;
        logic [9:0]  head;
        logic [20:0] log_base;
    } rope_cfg_t;

    // The scoreboard keeps its own register copy and computes the rotated pair for
    // every accepted item, then compares results in order.
    class rotation_scoreboard;
        rope_cfg_t cfg;
        y_item_t   expected_y[$];
        longint unsigned half_pow[16];
        int        fails;

        function new();
            cfg = '{1'b0, 10'd32, 10'd48, 10'd48, 10'd128, 21'd870822};
            fails = 0;
            half_pow[0] = root64(64'd1 << 59);
            for (int k = 1; k < 16; k++)
            begin
                half_pow[k] = root64(half_pow[k - 1] << 30);
            end
        endfunction

        function longint unsigned root64(longint unsigned v_in);
            longint unsigned v, res, bit_w;
            v = v_in;
            res = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > v)
            begin
                bit_w = bit_w >> 2;
            end
            while (bit_w != 0)
            begin
                if (v >= res + bit_w)
                begin
                    v = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end
                else
                begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
            return res;
        endfunction

        function void write_reg(logic [2:0] idx, logic [20:0] data);
            case (idx)
                REG_MODE:      cfg.mode = data[0];
                REG_SEC_T:     cfg.sec_t = data[9:0];
                REG_SEC_H:     cfg.sec_h = data[9:0];
                REG_SEC_W:     cfg.sec_w = data[9:0];
                REG_HEAD:      cfg.head = (data[9:0] > MAX_HEAD_DIM) ? 10'(MAX_HEAD_DIM)
                                                                   : data[9:0];
                REG_LOG2_BASE: cfg.log_base = data;
                default:       ;
            endcase
        endfunction

        function void note_pair(x_item_t it);
            longint unsigned pos, loc, sz, lb, e, freq, frac, ang, ht, hh;
            longint r, cx, cy, z, dx, dy, c, s, y0, y1;
            bit neg;
            y_item_t res;
            neg = 0;
            if (cfg.mode)
            begin
                case (it.pair_index % 3)
                    0:       pos = it.pos_t;
                    1:       pos = it.pos_h;
                    default: pos = it.pos_w;
                endcase
                loc = it.pair_index / 3;
                sz = (cfg.head + 2) / 3;
                lb = LOG2_10000_Q16;
            end
            else
            begin
                ht = cfg.sec_t >> 1;
                hh = cfg.sec_h >> 1;
                if (it.pair_index < ht)
                begin
                    pos = it.pos_t; loc = it.pair_index; sz = cfg.sec_t;
                end
                else if (it.pair_index < ht + hh)
                begin
                    pos = it.pos_h; loc = it.pair_index - ht; sz = cfg.sec_h;
                end
                else
                begin
                    pos = it.pos_w; loc = it.pair_index - ht - hh; sz = cfg.sec_w;
                end
                lb = cfg.log_base;
            end
            e = (sz != 0) ? (lb * 2 * loc) / sz : 0;
            // Frequency is 2^-E built from the square-root chain, then shifted.
            freq = 64'd1 << 30;
            frac = e & 64'hFFFF;
            for (int k = 0; k < 16; k++)
            begin
                if (frac[15 - k])
                begin
                    freq = (freq * half_pow[k]) >> 30;
                end
            end
            freq = ((e >> 16) > 30) ? 0 : freq >> (e >> 16);
            ang = (pos * freq) % TWO_PI_Q30;
            r = longint'(ang);
            if (r > longint'(PI_Q30))
            begin
                r = r - longint'(TWO_PI_Q30);
            end
            if (r > longint'(HALF_PI_Q30))
            begin
                r = r - longint'(PI_Q30);
                neg = 1;
            end
            else if (r < -longint'(HALF_PI_Q30))
            begin
                r = r + longint'(PI_Q30);
                neg = 1;
            end
            cx = longint'(CORDIC_GAIN);
            cy = 0;
            z = r;
            for (int i = 0; i < CORDIC_STAGES_DEF; i++)
            begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (z >= 0)
                begin
                    cx = cx - dx; cy = cy + dy; z = z - longint'(ATAN_Q30[i]);
                end
                else
                begin
                    cx = cx + dx; cy = cy - dy; z = z + longint'(ATAN_Q30[i]);
                end
            end
            c = neg ? -cx : cx;
            s = neg ? -cy : cy;
            y0 = (longint'(it.x_first) * c - longint'(it.x_second) * s
                  + (longint'(1) << 29)) >>> 30;
            y1 = (longint'(it.x_first) * s + longint'(it.x_second) * c
                  + (longint'(1) << 29)) >>> 30;
            res.saturated = 0;
            if (y0 > 32767 || y0 < -32768)
            begin
                res.saturated = 1;
                y0 = (y0 > 0) ? 32767 : -32768;
            end
            if (y1 > 32767 || y1 < -32768)
            begin
                res.saturated = 1;
                y1 = (y1 > 0) ? 32767 : -32768;
            end
            res.y_first = 16'(y0);
            res.y_second = 16'(y1);
            expected_y.push_back(res);
        endfunction

        function void check_result(y_item_t got);
            y_item_t want;
            if (expected_y.size() == 0)
            begin
                $display("%0t: unexpected result item %h", $time, got);
                fails++;
                return;
            end
            want = expected_y.pop_front();
            if (got.y_first !== want.y_first)
            begin
                $display("%0t: y_first expected %0d actual %0d", $time, want.y_first,
                         got.y_first);
                fails++;
            end
            if (got.y_second !== want.y_second)
            begin
                $display("%0t: y_second expected %0d actual %0d", $time, want.y_second,
                         got.y_second);
                fails++;
            end
            if (got.saturated !== want.saturated)
            begin
                $display("%0t: saturated expected %0b actual %0b", $time, want.saturated,
                         got.saturated);
                fails++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       x_valid;
    logic       x_ready;
    x_item_t    x_item;
    logic       y_valid;
    logic       y_ready;
    y_item_t    y_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [20:0] cfg_data;

    // When set, neither side inserts idle cycles.
    bit no_idle;
    rotation_scoreboard rope_sb;

    multimodal_rotary_position_embed_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .x_valid   (x_valid),
        .x_ready   (x_ready),
        .x_item    (x_item),
        .y_valid   (y_valid),
        .y_ready   (y_ready),
        .y_item    (y_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The clock starts low so that the first rising edge falls at 5 ns.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offers one item, with random idle cycles in front of it. After acceptance the
    // valid stays high so that the next call can keep streaming without a gap.
    task automatic push_pair(x_item_t it);
        while (!no_idle && $urandom_range(99) < 38)
        begin
            x_valid <= 1'b0;
            @(posedge clk);
        end
        x_valid <= 1'b1;
        x_item <= it;
        do
        begin
            @(posedge clk);
        end
        while (!x_ready);
        rope_sb.note_pair(it);
    endtask

    // Stops the input and waits until every expected result has arrived, then lets
    // the pipeline settle for its latency.
    task automatic drain_pipeline();
        x_valid <= 1'b0;
        while (rope_sb.expected_y.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY + 8) @(posedge clk);
    endtask

    // Writes every register in one back-to-back burst, plus a write to an unused
    // index that must be ignored.
    task automatic load_config(rope_cfg_t c);
        logic [2:0]  idx[7];
        logic [20:0] val[7];
        idx = '{REG_MODE, REG_SEC_T, REG_SEC_H, REG_SEC_W, REG_HEAD, REG_LOG2_BASE,
                REG_NONE};
        val = '{21'(c.mode), 21'(c.sec_t), 21'(c.sec_h), 21'(c.sec_w), 21'(c.head),
                c.log_base, 21'($urandom)};
        for (int i = 0; i < 7; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do
            begin
                @(posedge clk);
            end
            while (!cfg_ready);
            rope_sb.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_pos();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
        begin
            return 16'($urandom);
        end
        else if (sel < 8)
        begin
            return 16'($urandom_range(64));
        end
        return sel[0] ? 16'hFFFF : 16'h0000;
    endfunction

    function automatic logic [15:0] pick_x();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
        begin
            return 16'h8000;
        end
        else if (sel == 1)
        begin
            return 16'h7FFF;
        end
        return 16'($urandom);
    endfunction

    function automatic x_item_t random_pair();
        x_item_t it;
        it.x_first = pick_x();
        it.x_second = pick_x();
        // Most pair indexes sit inside a realistic head; some cover the full range.
        it.pair_index = ($urandom_range(9) < 8) ? 8'($urandom_range(70))
                                                : 8'($urandom);
        it.pos_t = pick_pos();
        it.pos_h = pick_pos();
        it.pos_w = pick_pos();
        return it;
    endfunction

    // The receiver takes result items whenever it is ready and stalls at random.
    initial
    begin
        y_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (y_valid && y_ready)
            begin
                rope_sb.check_result(y_item);
            end
            y_ready <= no_idle || ($urandom_range(99) >= 38);
        end
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rope_cfg_t phases[8];
        x_item_t   it;
        logic [7:0] edge_idx[8];

        rope_sb = new();
        no_idle = 0;
        rst_n = 1'b0;
        x_valid = 1'b0;
        x_item = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;

        // Zero section sizes, full sections with the largest base, interleaved with
        // saturated and minimum head sizes, oversized and inconsistent sections.
        phases[0] = '{1'b0, 10'd0, 10'd0, 10'd0, 10'd2, 21'd0};
        phases[1] = '{1'b0, 10'd512, 10'd512, 10'd512, 10'd512, 21'h1FFFFF};
        phases[2] = '{1'b1, 10'd32, 10'd48, 10'd48, 10'd1023, 21'd870822};
        phases[3] = '{1'b1, 10'd0, 10'd0, 10'd0, 10'd2, 21'd0};
        phases[4] = '{1'b0, 10'd1023, 10'd1023, 10'd1023, 10'd128, 21'h1FFFFF};
        phases[5] = '{1'b0, 10'd8, 10'd16, 10'd3, 10'd96, 21'($urandom)};
        for (int p = 6; p < 8; p++)
        begin
            phases[p] = '{1'($urandom), 10'($urandom), 10'($urandom_range(128)),
                          10'($urandom), 10'($urandom), 21'($urandom)};
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at the reset setting: extremes of the data, positions and
        // pair indexes on either side of each section boundary.
        edge_idx = '{8'd0, 8'd15, 8'd16, 8'd39, 8'd40, 8'd63, 8'd64, 8'd255};
        for (int i = 0; i < 8; i++)
        begin
            it.x_first = (i % 2) ? 16'h8000 : 16'h7FFF;
            it.x_second = (i % 3 == 0) ? 16'h7FFF : 16'h8000;
            it.pair_index = edge_idx[i];
            it.pos_t = (i < 4) ? 16'hFFFF : 16'h0000;
            it.pos_h = (i < 4) ? 16'h0000 : 16'hFFFF;
            it.pos_w = 16'hFFFF;
            push_pair(it);
        end
        // Zero position gives no rotation; position one at pair index zero (one radian) drives saturation.
        it = '{16'sh8000, 16'sh8000, 8'd0, 16'd0, 16'd0, 16'd0};
        push_pair(it);
        it = '{16'sh7FFF, 16'sh7FFF, 8'd0, 16'd1, 16'd0, 16'd0};
        push_pair(it);
        it = '{16'sh0000, 16'sh0000, 8'd200, 16'd3, 16'd3, 16'd3};
        push_pair(it);
        for (int i = 0; i < 10; i++)
        begin
            push_pair(random_pair());
        end

        for (int p = 0; p < 8; p++)
        begin
            drain_pipeline();
            load_config(phases[p]);
            // One phase streams with no idling on either side.
            no_idle = (p == 2);
            for (int n = 0; n < 165; n++)
            begin
                push_pair(random_pair());
            end
        end
        no_idle = 0;

        drain_pipeline();
        if (rope_sb.fails == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
design/mrope_pkg.sv
design/mrope_div_cell.sv
design/mrope_exp_cell.sv
design/mrope_mod_cell.sv
design/mrope_cordic_cell.sv
design/multimodal_rotary_position_embed_top.sv
design/mrope_checker.sv
bench/multimodal_rotary_position_embed_top_tb.sv
